@@ rtl/fxsc_pkg.sv @@
// ----------------------------------------------------------------------------
// fxsc_pkg
// Shared types, multiplier constants and the segment table of the
// fixed-point sine/cosine core.
// ----------------------------------------------------------------------------
package fxsc_pkg;

   localparam int WORD_W   = 32;
   localparam int SEG_W    = 5;
   localparam int ARG_W    = 30;
   localparam int OFS_W    = 26;
   localparam int BB_W     = 28;
   localparam int T_W      = 22;
   localparam int S3_W     = 26;
   localparam int SMALL_W  = 20;
   localparam int MULHI_SH = 32;

   localparam logic signed [WORD_W-1:0] K_TWO_PI    = 32'sh6487ed51;
   localparam logic signed [WORD_W-1:0] K_SIN_SIXTH = 32'shd5555556;
   localparam logic signed [WORD_W-1:0] K_COS_SIXTH = 32'sh2aaaaaab;
   localparam logic signed [OFS_W-1:0]  HALF_SEG    = 26'sh100_0000;

   localparam logic [WORD_W-1:0] SEG_ROM [64] = '{
      32'h3ffec42d, 32'h00c90e90, 32'h3ff4e5e0, 32'h025b0caf,
      32'h3fe12acb, 32'h03ecadcf, 32'h3fc395f9, 32'h057db403,
      32'h3f9c2bfb, 32'h070de172, 32'h3f6af2e3, 32'h089cf867,
      32'h3f2ff24a, 32'h0a2abb59, 32'h3eeb3347, 32'h0bb6ecef,
      32'h3e9cc076, 32'h0d415013, 32'h3e44a5ef, 32'h0ec9a7f3,
      32'h3de2f148, 32'h104fb80e, 32'h3d77b192, 32'h11d3443f,
      32'h3d02f757, 32'h135410c3, 32'h3c84d496, 32'h14d1e242,
      32'h3bfd5cc4, 32'h164c7ddd, 32'h3b6ca4c4, 32'h17c3a931,
      32'h3ad2c2e8, 32'h19372a64, 32'h3a2fcee8, 32'h1aa6c82b,
      32'h3983e1e8, 32'h1c1249d8, 32'h38cf1669, 32'h1d79775c,
      32'h3811884d, 32'h1edc1953, 32'h374b54ce, 32'h2039f90f,
      32'h367c9a7e, 32'h2192e09b, 32'h35a5793c, 32'h22e69ac8,
      32'h34c61236, 32'h2434f332, 32'h33de87de, 32'h257db64c,
      32'h32eefdea, 32'h26c0b162, 32'h31f79948, 32'h27fdb2a7,
      32'h30f8801f, 32'h29348937, 32'h2ff1d9c7, 32'h2a650525,
      32'h2ee3cebe, 32'h2b8ef77d, 32'h2dce88aa, 32'h2cb2324c
   };

   typedef struct packed {
      logic use_cos;
      logic flip;
      logic zero;
   } fxsc_flag_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] base;
      logic signed [WORD_W-1:0] other;
      logic signed [OFS_W-1:0]  ofs;
      fxsc_flag_type            flags;
   } fxsc_fold_type;

endpackage

@@ rtl/fxsc_mulhi.sv @@
// ----------------------------------------------------------------------------
// fxsc_mulhi
// Signed multiply returning floor(a * b / 2^32), truncated to R_W bits.
// ----------------------------------------------------------------------------
module fxsc_mulhi #(
   parameter int A_W = 32,
   parameter int B_W = 32,
   parameter int R_W = 32
) (
   input  logic signed [A_W-1:0] a,
   input  logic signed [B_W-1:0] b,
   output logic signed [R_W-1:0] hi
);
   import fxsc_pkg::*;

   localparam int P_W = A_W + B_W;

   logic signed [P_W-1:0] prod;
   logic signed [P_W-1:0] shifted;

   assign prod    = a * b;
   assign shifted = prod >>> MULHI_SH;
   assign hi      = shifted[R_W-1:0];

endmodule

@@ rtl/fxsc_fold.sv @@
// ----------------------------------------------------------------------------
// fxsc_fold
// Folds the angle into an octant argument, looks up the segment pair and
// derives the selection, sign and exact-zero flags.
// ----------------------------------------------------------------------------
module fxsc_fold (
   input  logic                             command,
   input  logic [fxsc_pkg::WORD_W-1:0]      angle,
   output fxsc_pkg::fxsc_fold_type          fold
);
   import fxsc_pkg::*;

   logic              half_neg;
   logic              quad_hi;
   logic              first;
   logic [ARG_W-1:0]  arg;
   logic [WORD_W-1:0] mirror;
   logic [SEG_W-1:0]  seg;
   logic [WORD_W-1:0] cos_w;
   logic [WORD_W-1:0] sin_w;
   logic              use_cos;

   assign half_neg = angle[31];
   assign quad_hi  = angle[30];
   assign first    = ~angle[29];
   assign mirror   = 32'h8000_0000 - {1'b0, angle[29:0], 1'b0};

   always_comb begin
      priority if (first) begin
         arg = {angle[28:0], 1'b0};
      end else if (angle[28:0] == '0) begin
         arg = {ARG_W{1'b1}};
      end else begin
         arg = mirror[ARG_W-1:0];
      end
   end

   assign seg     = arg[ARG_W-1 -: SEG_W];
   assign cos_w   = SEG_ROM[{seg, 1'b0}] ^ {WORD_W{half_neg}};
   assign sin_w   = SEG_ROM[{seg, 1'b1}] ^ {WORD_W{half_neg}};
   assign use_cos = first ^ quad_hi ^ ~command;

   always_comb begin
      fold.base          = use_cos ? cos_w : sin_w;
      fold.other         = use_cos ? sin_w : cos_w;
      fold.ofs           = $signed({1'b0, arg[24:0]}) - HALF_SEG;
      fold.flags.use_cos = use_cos;
      fold.flags.flip    = command & quad_hi;
      fold.flags.zero    = (~command & (angle[30:0] == '0))
                         | (command & quad_hi & (angle[29:0] == '0));
   end

endmodule

@@ rtl/fixed_point_sine_cosine_core.sv @@
// ----------------------------------------------------------------------------
// fixed_point_sine_cosine_core
// Pipelined table plus third-order Taylor sine/cosine in signed Q30.
// ----------------------------------------------------------------------------
// Accepts one transaction per clock, while the result side does not stall,
// through six register stages. The stages are: the octant fold and table
// lookup, the scaled offset, its square and the cross term, the second-order
// term and the cubic factor, the final correction product, and the closing
// sum with its sign. Stalls back up stage by stage, and empty stages are
// filled while a finished result waits. The block holds no state between
// transactions.
module fixed_point_sine_cosine_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_command,
   input  logic [fxsc_pkg::WORD_W-1:0]        req_angle,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [fxsc_pkg::WORD_W-1:0] rsp_value
);
   import fxsc_pkg::*;

   localparam int STAGES = 6;

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES-1:0] rdy;

   fxsc_fold_type fold;

   // stage 0
   fxsc_fold_type              s0_ff;
   // stage 1
   logic signed [WORD_W-1:0]   s1_base_ff, s1_other_ff;
   logic signed [BB_W-1:0]     s1_bb_ff;
   fxsc_flag_type              s1_flags_ff;
   // stage 2
   logic signed [WORD_W-1:0]   s2_base_ff;
   logic signed [T_W-1:0]      s2_t_ff;
   logic signed [S3_W-1:0]     s2_s3_ff;
   fxsc_flag_type              s2_flags_ff;
   // stage 3
   logic signed [WORD_W-1:0]   s3_base_ff;
   logic signed [S3_W-1:0]     s3_s3_ff;
   logic signed [SMALL_W-1:0]  s3_s2_ff, s3_u_ff;
   fxsc_flag_type              s3_flags_ff;
   // stage 4
   logic signed [WORD_W-1:0]   s4_acc_ff;
   logic signed [SMALL_W-1:0]  s4_s4_ff;
   fxsc_flag_type              s4_flags_ff;
   // stage 5
   logic signed [WORD_W-1:0]   rsp_value_ff;

   logic signed [28:0]         ofs8;
   logic signed [BB_W-1:0]     bb_in;
   logic signed [T_W-1:0]      t_in;
   logic signed [S3_W-1:0]     s3_in;
   logic signed [T_W-1:0]      t_half;
   logic signed [WORD_W-1:0]   k_sixth;
   logic signed [SMALL_W-1:0]  s2_in, u_in, s4_in;
   logic signed [WORD_W-1:0]   acc_in;
   logic signed [WORD_W-1:0]   sum;
   logic signed [WORD_W-1:0]   value_in;

   assign rdy[5] = ~valid_ff[5] | rsp_ready;
   assign rdy[4] = ~valid_ff[4] | rdy[5];
   assign rdy[3] = ~valid_ff[3] | rdy[4];
   assign rdy[2] = ~valid_ff[2] | rdy[3];
   assign rdy[1] = ~valid_ff[1] | rdy[2];
   assign rdy[0] = ~valid_ff[0] | rdy[1];

   assign valid_in = {valid_ff[STAGES-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < STAGES; i++) begin
            if (rdy[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
      end
   end

   fxsc_fold u_fold (
      .command (req_command),
      .angle   (req_angle),
      .fold    (fold)
   );

   assign ofs8 = {s0_ff.ofs, 3'b000};

   fxsc_mulhi #(.A_W(29), .B_W(WORD_W), .R_W(BB_W)) u_mul_bb (
      .a (ofs8), .b (K_TWO_PI), .hi (bb_in)
   );

   fxsc_mulhi #(.A_W(BB_W), .B_W(BB_W), .R_W(T_W)) u_mul_t (
      .a (s1_bb_ff), .b (s1_bb_ff), .hi (t_in)
   );

   fxsc_mulhi #(.A_W(WORD_W), .B_W(BB_W), .R_W(S3_W)) u_mul_s3 (
      .a (s1_other_ff), .b (s1_bb_ff), .hi (s3_in)
   );

   assign t_half  = s2_t_ff >>> 1;
   assign k_sixth = s2_flags_ff.use_cos ? K_COS_SIXTH : K_SIN_SIXTH;

   fxsc_mulhi #(.A_W(WORD_W), .B_W(T_W), .R_W(SMALL_W)) u_mul_s2 (
      .a (s2_base_ff), .b (t_half), .hi (s2_in)
   );

   fxsc_mulhi #(.A_W(T_W), .B_W(WORD_W), .R_W(SMALL_W)) u_mul_u (
      .a (s2_t_ff), .b (k_sixth), .hi (u_in)
   );

   fxsc_mulhi #(.A_W(S3_W), .B_W(SMALL_W), .R_W(SMALL_W)) u_mul_s4 (
      .a (s3_s3_ff), .b (s3_u_ff), .hi (s4_in)
   );

   always_comb begin
      if (s3_flags_ff.use_cos) begin
         acc_in = s3_base_ff - WORD_W'(s3_s2_ff) - WORD_W'(s3_s3_ff);
      end else begin
         acc_in = s3_base_ff - WORD_W'(s3_s2_ff) + WORD_W'(s3_s3_ff);
      end
   end

   assign sum = s4_acc_ff + WORD_W'(s4_s4_ff);

   always_comb begin
      priority if (s4_flags_ff.zero) begin
         value_in = '0;
      end else if (s4_flags_ff.flip) begin
         value_in = '0 - sum;
      end else begin
         value_in = sum;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         s0_ff <= fold;
      end
      if (rdy[1]) begin
         s1_base_ff  <= s0_ff.base;
         s1_other_ff <= s0_ff.other;
         s1_bb_ff    <= bb_in;
         s1_flags_ff <= s0_ff.flags;
      end
      if (rdy[2]) begin
         s2_base_ff  <= s1_base_ff;
         s2_t_ff     <= t_in;
         s2_s3_ff    <= s3_in;
         s2_flags_ff <= s1_flags_ff;
      end
      if (rdy[3]) begin
         s3_base_ff  <= s2_base_ff;
         s3_s3_ff    <= s2_s3_ff;
         s3_s2_ff    <= s2_in;
         s3_u_ff     <= u_in;
         s3_flags_ff <= s2_flags_ff;
      end
      if (rdy[4]) begin
         s4_acc_ff   <= acc_in;
         s4_s4_ff    <= s4_in;
         s4_flags_ff <= s3_flags_ff;
      end
      if (rdy[5]) begin
         rsp_value_ff <= value_in;
      end
   end

   assign req_ready = rdy[0];
   assign rsp_valid = valid_ff[5];
   assign rsp_value = rsp_value_ff;

endmodule

@@ rtl/fxsc_checker.sv @@
// ----------------------------------------------------------------------------
// fxsc_checker
// Port-level checks of the sine/cosine core, bound to the top level.
// ----------------------------------------------------------------------------
module fxsc_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [fxsc_pkg::WORD_W-1:0] rsp_value
);
   import fxsc_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result transaction dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_value))
      else $error("result value changed while stalled");

   a_flow_through: assert property (@(posedge clock)
      rsp_ready |-> req_ready)
      else $error("input stalled while result side is ready");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind fixed_point_sine_cosine_core fxsc_checker u_fxsc_checker (.*);
